FILE: hw/rtl/sse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_pkg: shared types and constants of the sparse scatter entry filter
// Grid sizing, opcodes, modes, register indexes and the stage payloads.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int GRID_SIDE = 4;
  localparam int BRANCHES  = 4;
  localparam int PTS       = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int BPTS      = BRANCHES * PTS;

  localparam int IDX_W     = 14;
  localparam int IDX_SPAN  = 1 << IDX_W;
  localparam int Q_W       = ($clog2(IDX_SPAN / BPTS) < 1) ? 1 : $clog2(IDX_SPAN / BPTS);
  localparam int PT_W      = $clog2(PTS);
  localparam int BP_W      = $clog2(BPTS);
  localparam int BR_W      = (BRANCHES > 1) ? $clog2(BRANCHES) : 1;
  localparam int GW        = $clog2(GRID_SIDE);

  localparam int TABLE_DEPTH = 4096;
  localparam int TAB_AW      = 12;
  localparam int MAP_DEPTH   = 64;
  localparam int MAP_AW      = 6;
  localparam int PT_VAL_W    = 6;

  localparam logic [62:0] EXP_ALL = 63'h7FF0_0000_0000_0000;

  localparam logic [1:0] OP_TABLE_WRITE = 2'd0;
  localparam logic [1:0] OP_EXCLUDE     = 2'd1;
  localparam logic [1:0] OP_FILTER      = 2'd2;

  localparam logic [1:0] MODE_K_MAJOR = 2'd0;
  localparam logic [1:0] MODE_Q_MAJOR = 2'd1;
  localparam logic [1:0] MODE_NEG_K   = 2'd2;

  localparam logic REG_MODE      = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] table_address;
    logic [5:0]  table_value;
    logic [5:0]  excluded_point;
    logic [63:0] element_value;
    logic [13:0] element_index;
  } in_item_t;

  typedef struct packed {
    logic [63:0] kept_value;
    logic [7:0]  kept_branch_point;
    logic [11:0] kept_pair;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        opcode;
    logic [TAB_AW-1:0] table_address;
    logic [5:0]        table_value;
    logic [5:0]        excluded_point;
    logic [63:0]       value;
    logic              pass;
    logic [Q_W-1:0]    q;
    logic [7:0]        bp;
    logic [TAB_AW-1:0] addr;
    logic              addr_ok;
  } dec_t;

  typedef struct packed {
    logic           valid;
    logic [1:0]     opcode;
    logic [5:0]     excluded_point;
    logic [63:0]    value;
    logic           pass;
    logic [Q_W-1:0] q;
    logic [7:0]     bp;
    logic           addr_ok;
  } lkp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sse_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_decode: index decode and threshold stage
// Splits the packed index, applies the mode and compares the magnitude.
// ----------------------------------------------------------------------------
module sse_decode (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_v,
  input  wire sse_pkg::in_item_t in_item,
  input  wire logic [1:0]       mode,
  input  wire logic [62:0]      threshold,
  output sse_pkg::dec_t         dec
);
  import sse_pkg::*;

  logic [IDX_W-1:0] idx;
  logic [Q_W-1:0]   q;
  logic [PT_W-1:0]  k, kn;
  logic [BP_W-1:0]  bp;
  logic [BR_W-1:0]  br;
  logic [GW-1:0]    c0, c1, c2, n0, n1, n2;
  logic [62:0]      mag;
  logic [31:0]      addr32, bp32;
  logic             mag_ok;

  always_comb begin
    idx = in_item.element_index;
    q   = Q_W'(idx / BPTS);
    bp  = BP_W'(idx % BPTS);
    k   = PT_W'(idx % PTS);
    br  = BR_W'(bp / PTS);
    c0  = GW'(k % GRID_SIDE);
    c1  = GW'((k / GRID_SIDE) % GRID_SIDE);
    c2  = GW'(k / (GRID_SIDE * GRID_SIDE));
    n0  = (c0 == '0) ? '0 : GW'(GRID_SIDE - 32'(c0));
    n1  = (c1 == '0) ? '0 : GW'(GRID_SIDE - 32'(c1));
    n2  = (c2 == '0) ? '0 : GW'(GRID_SIDE - 32'(c2));
    kn  = PT_W'(32'(n0) + 32'(n1) * GRID_SIDE + 32'(n2) * GRID_SIDE * GRID_SIDE);
    case (mode)
      MODE_Q_MAJOR: begin
        addr32 = 32'(q) + 32'(k) * PTS;
        bp32   = 32'(bp);
      end
      MODE_NEG_K: begin
        addr32 = 32'(q) + 32'(kn) * PTS;
        bp32   = 32'(kn) + 32'(br) * PTS;
      end
      default: begin
        addr32 = 32'(k) + 32'(q) * PTS;
        bp32   = 32'(bp);
      end
    endcase
    mag    = in_item.element_value[62:0];
    mag_ok = (mag <= EXP_ALL) && (threshold <= EXP_ALL) && (mag > threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec.valid <= 1'b0;
    end else if (en) begin
      dec.valid <= in_v;
    end
    if (en) begin
      dec.opcode         <= in_item.opcode;
      dec.table_address  <= in_item.table_address;
      dec.table_value    <= in_item.table_value;
      dec.excluded_point <= in_item.excluded_point;
      dec.value          <= in_item.element_value;
      dec.pass           <= mag_ok && (k != '0);
      dec.q              <= q;
      dec.bp             <= bp32[7:0];
      dec.addr           <= addr32[TAB_AW-1:0];
      dec.addr_ok        <= addr32 < 32'(TABLE_DEPTH);
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sse_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_lookup: pairing table stage
// One write port for table loads, one registered read for the partner.
// ----------------------------------------------------------------------------
module sse_lookup (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire sse_pkg::dec_t dec,
  output sse_pkg::lkp_t      lkp,
  output logic [5:0]         partner_raw
);
  import sse_pkg::*;

  logic [PT_VAL_W-1:0] pair_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (dec.valid && dec.opcode == OP_TABLE_WRITE) begin
        pair_mem[dec.table_address] <= dec.table_value;
      end
      partner_raw <= pair_mem[dec.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lkp.valid <= 1'b0;
    end else if (en) begin
      lkp.valid <= dec.valid;
    end
    if (en) begin
      lkp.opcode         <= dec.opcode;
      lkp.excluded_point <= dec.excluded_point;
      lkp.value          <= dec.value;
      lkp.pass           <= dec.pass;
      lkp.q              <= dec.q;
      lkp.bp             <= dec.bp;
      lkp.addr_ok        <= dec.addr_ok;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sse_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_check: exclusion check and output register
// Holds the exclusion map, checks q and partner, forms the kept entry.
// ----------------------------------------------------------------------------
module sse_check (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire sse_pkg::lkp_t lkp,
  input  wire logic [5:0]    partner_raw,
  output logic               out_v,
  output sse_pkg::out_item_t out_item
);
  import sse_pkg::*;

  logic [MAP_DEPTH-1:0] excl;
  logic [5:0]           partner;
  logic                 q_bad, p_bad, keep;
  logic [31:0]          pair32;

  always_comb begin
    partner = lkp.addr_ok ? partner_raw : '0;
    q_bad   = (lkp.q == '0) ||
              ((32'(lkp.q) < 32'(MAP_DEPTH)) && excl[MAP_AW'(lkp.q)]);
    p_bad   = (partner == '0) || excl[partner];
    keep    = lkp.valid && (lkp.opcode == OP_FILTER) && lkp.pass && !q_bad && !p_bad;
    pair32  = 32'(lkp.q) + 32'(partner) * PTS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      excl  <= '0;
      out_v <= 1'b0;
    end else if (en) begin
      if (lkp.valid && lkp.opcode == OP_EXCLUDE) begin
        excl[lkp.excluded_point] <= 1'b1;
      end
      out_v <= keep;
    end
    if (en) begin
      out_item.kept_value        <= lkp.value;
      out_item.kept_branch_point <= lkp.bp;
      out_item.kept_pair         <= pair32[11:0];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sparse_scatter_entry_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_scatter_entry_filter: streaming filter for sparse scattering entries
// Keeps entries above a magnitude threshold whose points and table partner
// are nonzero and not excluded; loads the pairing table and exclusion map.
// ----------------------------------------------------------------------------
//  channel | signals                         | transfer when
//  --------+---------------------------------+----------------------------
//  in      | in_valid, in_stall, in_data     | in_valid && !in_stall
//  out     | out_valid, out_stall, out_data  | out_valid && !out_stall
//  cfg     | cfg_valid, cfg_ready, cfg_index,| cfg_valid && cfg_ready
//          | cfg_data                        |
//
// One item per cycle while out is not stalled; four register stages (input,
// decode, table read, exclusion check/output).
// The pairing table has one write port for loads and one registered read port.
// A stall on out while out_valid is high freezes every stage at once; in_stall follows it directly.
// Synchronous reset clears the valid bits, the exclusion map and the configuration registers.
// The pairing table is not cleared and must be loaded before it is read.
// ----------------------------------------------------------------------------
module sparse_scatter_entry_filter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sse_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sse_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [63:0]        cfg_data
);
  import sse_pkg::*;

  logic        en;
  logic        s0_valid;
  in_item_t    s0_item;
  logic [1:0]  mode;
  logic [62:0] threshold;
  dec_t        dec;
  lkp_t        lkp;
  logic [5:0]  partner_raw;

  // Advance the whole pipe unless a result is held at the output.
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_K_MAJOR;
      threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:      mode      <= cfg_data[1:0];
        REG_THRESHOLD: threshold <= cfg_data[62:0];
        default:       mode      <= mode;
      endcase
    end
  end

  // Input register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
    if (en) begin
      s0_item <= in_data;
    end
  end

  sse_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_v      (s0_valid),
    .in_item   (s0_item),
    .mode      (mode),
    .threshold (threshold),
    .dec       (dec)
  );

  sse_lookup u_lookup (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .dec         (dec),
    .lkp         (lkp),
    .partner_raw (partner_raw)
  );

  sse_check u_check (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .lkp         (lkp),
    .partner_raw (partner_raw),
    .out_v       (out_valid),
    .out_item    (out_data)
  );

  // Output drains when nothing is in the last stage.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!out_stall && !lkp.valid) |=> !out_valid)
    else $error("result appeared without an item in the check stage");

  // A kept value never carries a NaN magnitude.
  a_finite: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.kept_value[62:0] <= EXP_ALL))
    else $error("NaN entry passed the threshold");

  // A kept value is strictly above the threshold.
  a_above: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.kept_value[62:0] > threshold))
    else $error("kept entry not above threshold");

  // Only a filter item can reach the output.
  a_filter_only: assert property (@(posedge clk) disable iff (rst)
    (en && lkp.valid && lkp.opcode != OP_FILTER) |=> !out_valid)
    else $error("load opcode produced a result");

endmodule
`default_nettype wire
